FILE: rtl/gq_pkg.sv
// shared constants, types and the elaboration-time log2 for the gumbel quantile core
package gq_pkg;

   localparam int          PROB_BITS_DEF = 32;
   localparam int          LOG2_STEPS    = 56;
   localparam logic [63:0] LN2_Q64       = 64'hB17217F7D1CF79AC;

   localparam logic [1:0]  CSR_LOCATION   = 2'd0;
   localparam logic [1:0]  CSR_SCALE      = 2'd1;
   localparam logic [1:0]  CSR_UPPER_TAIL = 2'd2;

   localparam logic [31:0] LOCATION_RST = 32'd0;
   localparam logic [30:0] SCALE_RST    = 31'd65536;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic sat_lo;
      logic sat_hi;
   } special_type;

   // log2 in unsigned Q.56 by repeated squaring, for constants only
   function automatic logic [63:0] log2_q56(input logic [63:0] v);
      logic [63:0]  x;
      logic [5:0]   k;
      logic [55:0]  frac;
      logic [127:0] sq;
      x    = v;
      k    = 6'd63;
      frac = '0;
      for (int i = 0; i < 63; i++) begin
         if (!x[63]) begin
            x = x << 1;
            k = k - 6'd1;
         end
      end
      for (int i = 0; i < LOG2_STEPS; i++) begin
         sq = {64'd0, x} * {64'd0, x};
         if (sq[127]) begin
            x = sq[127:64];
            frac[LOG2_STEPS-1-i] = 1'b1;
         end else begin
            x = sq[126:63];
         end
      end
      return {2'b00, k, frac};
   endfunction

   // log2(LN2_Q64) - 64 - 56, all in Q.56: added to log2(t) gives log2(-ln p)
   localparam logic [63:0] S_BIAS = log2_q56(LN2_Q64) - (64'd64 << 56) - (64'd56 << 56);

endpackage

FILE: rtl/gumbel_quantile_core.sv
// gumbel quantile core: location - scale * ln(-ln p) in signed fixed point
//
//   channel  ports                                direction
//   request  req_valid req_ready req_prob         in
//   response rsp_valid rsp_ready rsp_quantile     out
//            rsp_saturated
//   config   csr_we csr_index csr_wdata           in
//
// one beat per cycle while req_ready is high; most of the pipeline depth is in
// the two log2 pipelines (two stages per squaring step, 56 steps each)
// a two-entry output register and skid stage; req_ready drops only when both hold
// beats, then the whole pipeline holds and nothing is lost or repeated
// reset is synchronous and clears valid bits and the configuration registers
module gumbel_quantile_core #(
   parameter int PROB_BITS = gq_pkg::PROB_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_prob,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_quantile,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import gq_pkg::*;

   localparam logic [63:0] ONE       = 64'd1 << PROB_BITS;
   localparam logic [63:0] PROB_MASK = ONE - 64'd1;
   localparam logic [63:0] T_BIAS    = 64'(PROB_BITS) << 56;

   logic [31:0] location_ff;
   logic [30:0] scale_ff;
   logic        upper_tail_ff;

   logic        en;
   logic [63:0] cm_in, ce_in;
   special_type sp_in;

   logic        pr_v_ff;
   logic [63:0] pr_c_ff;
   special_type pr_sp_ff;

   logic        l1_v, l2_v;
   logic [63:0] l1_y, l2_y;
   special_type l1_sp, l2_sp;

   logic        t_v_ff;
   logic [63:0] t_ff;
   special_type t_sp_ff;

   logic [63:0] s_in;
   logic        m_v_ff;
   logic [63:0] m_mag_ff;
   logic        m_neg_ff;
   special_type m_sp_ff;

   logic        af_v, af_neg;
   logic [39:0] af_term;
   special_type af_sp;

   logic signed [41:0] r_in;
   logic [31:0]        q_in;
   logic               sat_in;
   logic               push;

   logic        out_v_ff, skid_v_ff;
   logic [31:0] out_q_ff, skid_q_ff;
   logic        out_s_ff, skid_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         location_ff   <= LOCATION_RST;
         scale_ff      <= SCALE_RST;
         upper_tail_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOCATION:   location_ff   <= csr_wdata;
            CSR_SCALE:      scale_ff      <= csr_wdata[30:0];
            CSR_UPPER_TAIL: upper_tail_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign en        = !skid_v_ff;
   assign req_ready = en;

   always_comb begin
      cm_in        = {32'd0, req_prob} & PROB_MASK;
      ce_in        = upper_tail_ff ? (ONE - cm_in) : cm_in;
      sp_in.sat_lo = (ce_in == '0);
      sp_in.sat_hi = (ce_in >= ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
         t_v_ff  <= 1'b0;
         m_v_ff  <= 1'b0;
      end else if (en) begin
         pr_v_ff <= req_valid;
         t_v_ff  <= l1_v;
         m_v_ff  <= l2_v;
      end
      if (en) begin
         pr_c_ff  <= ce_in;
         pr_sp_ff <= sp_in;
         t_ff     <= T_BIAS - l1_y;
         t_sp_ff  <= l1_sp;
         m_neg_ff <= s_in[63];
         m_mag_ff <= s_in[63] ? (64'd0 - s_in) : s_in;
         m_sp_ff  <= l2_sp;
      end
   end

   gq_log2 u_log2_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pr_v_ff),
      .in_x      (pr_c_ff),
      .in_sp     (pr_sp_ff),
      .out_valid (l1_v),
      .out_y     (l1_y),
      .out_sp    (l1_sp)
   );

   gq_log2 u_log2_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t_v_ff),
      .in_x      (t_ff),
      .in_sp     (t_sp_ff),
      .out_valid (l2_v),
      .out_y     (l2_y),
      .out_sp    (l2_sp)
   );

   assign s_in = l2_y + S_BIAS;

   gq_affine u_affine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_v_ff),
      .in_mag    (m_mag_ff),
      .in_neg    (m_neg_ff),
      .in_sp     (m_sp_ff),
      .scale     (scale_ff),
      .out_valid (af_v),
      .out_term  (af_term),
      .out_neg   (af_neg),
      .out_sp    (af_sp)
   );

   always_comb begin
      r_in = af_neg ? (42'(signed'(location_ff)) + signed'({2'b00, af_term}))
                    : (42'(signed'(location_ff)) - signed'({2'b00, af_term}));
      if (af_sp.sat_lo) begin
         q_in   = Q_MIN;
         sat_in = 1'b1;
      end else if (af_sp.sat_hi) begin
         q_in   = Q_MAX;
         sat_in = 1'b1;
      end else if (r_in > 42'(Q_MAX)) begin
         q_in   = Q_MAX;
         sat_in = 1'b1;
      end else if (r_in < 42'(Q_MIN)) begin
         q_in   = Q_MIN;
         sat_in = 1'b1;
      end else begin
         q_in   = r_in[31:0];
         sat_in = 1'b0;
      end
   end

   assign push = af_v && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         out_v_ff  <= skid_v_ff || push;
         skid_v_ff <= 1'b0;
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
      if (!out_v_ff || rsp_ready) begin
         out_q_ff <= skid_v_ff ? skid_q_ff : q_in;
         out_s_ff <= skid_v_ff ? skid_s_ff : sat_in;
      end else if (push) begin
         skid_q_ff <= q_in;
         skid_s_ff <= sat_in;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_quantile  = out_q_ff;
   assign rsp_saturated = out_s_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ready) |=> !skid_v_ff)
      else $error("skid beat not moved on after output was taken");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_quantile == Q_MAX || rsp_quantile == Q_MIN))
      else $error("saturated flag with a value inside range");

endmodule

FILE: rtl/gq_log2.sv
// pipelined log2 of a nonzero 64-bit word, unsigned Q.56, one squaring per two stages
module gq_log2 (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [63:0]         in_x,
   input  gq_pkg::special_type in_sp,
   output logic                out_valid,
   output logic [63:0]         out_y,
   output gq_pkg::special_type out_sp
);
   import gq_pkg::*;

   logic [63:0] xa_in, xb_in;
   logic [5:0]  ka_in, kb_in;

   logic        na_v_ff;
   logic [63:0] na_x_ff;
   logic [5:0]  na_k_ff;
   special_type na_sp_ff;

   logic        sv_ff  [LOG2_STEPS+1];
   logic [63:0] sx_ff  [LOG2_STEPS+1];
   logic [55:0] sf_ff  [LOG2_STEPS+1];
   logic [5:0]  sk_ff  [LOG2_STEPS+1];
   special_type ssp_ff [LOG2_STEPS+1];

   logic        pv_ff  [LOG2_STEPS];
   logic [63:0] p00_ff [LOG2_STEPS];
   logic [63:0] p01_ff [LOG2_STEPS];
   logic [63:0] p11_ff [LOG2_STEPS];
   logic [55:0] pf_ff  [LOG2_STEPS];
   logic [5:0]  pk_ff  [LOG2_STEPS];
   special_type psp_ff [LOG2_STEPS];

   // leading-one search, coarse part
   always_comb begin
      xa_in = in_x;
      ka_in = 6'd63;
      if (xa_in[63:32] == '0) begin
         xa_in = xa_in << 32;
         ka_in = ka_in - 6'd32;
      end
      if (xa_in[63:48] == '0) begin
         xa_in = xa_in << 16;
         ka_in = ka_in - 6'd16;
      end
      if (xa_in[63:56] == '0) begin
         xa_in = xa_in << 8;
         ka_in = ka_in - 6'd8;
      end
   end

   // leading-one search, fine part
   always_comb begin
      xb_in = na_x_ff;
      kb_in = na_k_ff;
      if (xb_in[63:60] == '0) begin
         xb_in = xb_in << 4;
         kb_in = kb_in - 6'd4;
      end
      if (xb_in[63:62] == '0) begin
         xb_in = xb_in << 2;
         kb_in = kb_in - 6'd2;
      end
      if (!xb_in[63]) begin
         xb_in = xb_in << 1;
         kb_in = kb_in - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         na_v_ff  <= 1'b0;
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         na_v_ff  <= in_valid;
         sv_ff[0] <= na_v_ff;
      end
      if (en) begin
         na_x_ff   <= xa_in;
         na_k_ff   <= ka_in;
         na_sp_ff  <= in_sp;
         sx_ff[0]  <= xb_in;
         sk_ff[0]  <= kb_in;
         sf_ff[0]  <= '0;
         ssp_ff[0] <= na_sp_ff;
      end
   end

   for (genvar i = 0; i < LOG2_STEPS; i++) begin : g_step
      localparam int FB = LOG2_STEPS - 1 - i;
      logic [127:0] sq_in;
      logic [63:0]  x_in;
      logic [55:0]  f_in;

      always_comb begin
         sq_in = {p11_ff[i], p00_ff[i]} + ({64'd0, p01_ff[i]} << 33);
         f_in  = pf_ff[i];
         if (sq_in[127]) begin
            x_in     = sq_in[127:64];
            f_in[FB] = 1'b1;
         end else begin
            x_in = sq_in[126:63];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[i]   <= 1'b0;
            sv_ff[i+1] <= 1'b0;
         end else if (en) begin
            pv_ff[i]   <= sv_ff[i];
            sv_ff[i+1] <= pv_ff[i];
         end
         if (en) begin
            p00_ff[i]   <= sx_ff[i][31:0] * sx_ff[i][31:0];
            p01_ff[i]   <= sx_ff[i][31:0] * sx_ff[i][63:32];
            p11_ff[i]   <= sx_ff[i][63:32] * sx_ff[i][63:32];
            pf_ff[i]    <= sf_ff[i];
            pk_ff[i]    <= sk_ff[i];
            psp_ff[i]   <= ssp_ff[i];
            sx_ff[i+1]  <= x_in;
            sf_ff[i+1]  <= f_in;
            sk_ff[i+1]  <= pk_ff[i];
            ssp_ff[i+1] <= psp_ff[i];
         end
      end
   end

   assign out_valid = sv_ff[LOG2_STEPS];
   assign out_y     = {2'b00, sk_ff[LOG2_STEPS], sf_ff[LOG2_STEPS]};
   assign out_sp    = ssp_ff[LOG2_STEPS];

endmodule

FILE: rtl/gq_affine.sv
// scale * ln2 * |s| with rounding to the output fraction, four stages
module gq_affine (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [63:0]         in_mag,
   input  logic                in_neg,
   input  gq_pkg::special_type in_sp,
   input  logic [30:0]         scale,
   output logic                out_valid,
   output logic [39:0]         out_term,
   output logic                out_neg,
   output gq_pkg::special_type out_sp
);
   import gq_pkg::*;

   logic [3:0]  v_ff;
   logic [3:0]  neg_ff;
   special_type sp_ff [4];

   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [127:0] ym_in;
   logic [63:0]  ym_ff;
   logic [62:0]  q0_ff, q1_ff;
   logic [95:0]  prod_in;
   logic [39:0]  term_ff;

   assign ym_in = {pp11_ff, 64'd0} + {32'd0, pp10_ff, 32'd0}
                + {32'd0, pp01_ff, 32'd0} + {64'd0, pp00_ff};
   assign prod_in = {1'b0, q1_ff, 32'd0} + {33'd0, q0_ff} + (96'd1 << 55);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      if (en) begin
         neg_ff   <= {neg_ff[2:0], in_neg};
         sp_ff[0] <= in_sp;
         sp_ff[1] <= sp_ff[0];
         sp_ff[2] <= sp_ff[1];
         sp_ff[3] <= sp_ff[2];
         pp00_ff  <= in_mag[31:0] * LN2_Q64[31:0];
         pp01_ff  <= in_mag[31:0] * LN2_Q64[63:32];
         pp10_ff  <= in_mag[63:32] * LN2_Q64[31:0];
         pp11_ff  <= in_mag[63:32] * LN2_Q64[63:32];
         ym_ff    <= ym_in[127:64];
         q0_ff    <= ym_ff[31:0] * scale;
         q1_ff    <= ym_ff[63:32] * scale;
         term_ff  <= prod_in[95:56];
      end
   end

   assign out_valid = v_ff[3];
   assign out_term  = term_ff;
   assign out_neg   = neg_ff[3];
   assign out_sp    = sp_ff[3];

endmodule

FILE: dv/tb_gumbel_quantile_core.sv
// testbench for the gumbel quantile core: directed and random probability beats with scoreboard
`timescale 1ns / 1ps

module tb_gumbel_quantile_core;
   import gq_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int         LATENCY   = 235;
   localparam int         WD_LIMIT  = 6000;
   localparam int         PHASE_LEN = 190;

   typedef struct {
      logic [31:0] quantile;
      logic        saturated;
   } quantile_type;

   class quantile_scoreboard;
      logic [31:0]  location = LOCATION_RST;
      logic [30:0]  scale    = SCALE_RST;
      logic         upper    = 1'b0;
      quantile_type pending[$];
      int           errors   = 0;

      function automatic logic [63:0] log2_fixed(input logic [63:0] v);
         logic [63:0]  x;
         logic [63:0]  k;
         logic [55:0]  frac;
         logic [127:0] sq;
         x    = v;
         k    = 63;
         frac = '0;
         while (!x[63]) begin
            x = x << 1;
            k = k - 1;
         end
         for (int i = 0; i < 56; i++) begin
            sq = {64'd0, x} * {64'd0, x};
            if (sq[127]) begin
               x = sq[127:64];
               frac[55-i] = 1'b1;
            end else begin
               x = sq[126:63];
            end
         end
         return (k << 56) | {8'd0, frac};
      endfunction

      function automatic quantile_type gumbel_quantile(input logic [31:0] prob);
         quantile_type res;
         logic [32:0]  code;
         logic [63:0]  t, mag, ym, hi, lo, term;
         logic [127:0] prod;
         logic [64:0]  lo2;
         longint       a, b, s, loc, r;
         code = {1'b0, prob};
         if (upper) code = 33'h1_0000_0000 - code;
         if (code == 0) begin
            res.quantile  = Q_MIN;
            res.saturated = 1'b1;
            return res;
         end
         if (code[32]) begin
            res.quantile  = Q_MAX;
            res.saturated = 1'b1;
            return res;
         end
         loc  = longint'(signed'(location));
         t    = (64'd32 << 56) - log2_fixed({31'd0, code});
         a    = longint'(log2_fixed(t)) - longint'(64'd56 << 56);
         b    = longint'(log2_fixed(LN2_Q64)) - longint'(64'd64 << 56);
         s    = a + b;
         mag  = (s < 0) ? 64'(-s) : 64'(s);
         prod = {64'd0, mag} * {64'd0, LN2_Q64};
         ym   = prod[127:64];
         prod = {64'd0, ym} * {97'd0, scale};
         hi   = prod[127:64];
         lo   = prod[63:0];
         lo2  = {1'b0, lo} + (65'd1 << 55);
         if (lo2[64]) hi = hi + 1;
         term = (hi << 8) | {56'd0, lo2[63:56]};
         r    = (s < 0) ? loc + longint'(term) : loc - longint'(term);
         res.saturated = 1'b0;
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            res.saturated = 1'b1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.saturated = 1'b1;
         end
         res.quantile = r[31:0];
         return res;
      endfunction

      function void note_request(input logic [31:0] prob);
         pending.push_back(gumbel_quantile(prob));
      endfunction

      function void check_response(input logic [31:0] quantile, input logic saturated);
         quantile_type exp_q;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result quantile %h sat %b", $time, quantile, saturated);
            errors++;
            return;
         end
         exp_q = pending.pop_front();
         if (exp_q.quantile !== quantile) begin
            $display("%0t: quantile expected %h actual %h", $time, exp_q.quantile, quantile);
            errors++;
         end
         if (exp_q.saturated !== saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_q.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_prob = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_quantile;
   logic        rsp_saturated;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   quantile_scoreboard sb = new();
   int send_idle  = 0;
   int recv_idle  = 0;
   int stall_left = 0;
   int quiet      = 0;

   gumbel_quantile_core u_top (.*);

   always #4 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_quantile, rsp_saturated);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= WD_LIMIT) begin
               $display("tb_gumbel_quantile_core NOT OK");
               $finish;
            end
         end
      end
   end

   task automatic send_beat(input logic [31:0] prob);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_prob  <= prob;
      do @(posedge clock); while (!req_ready);
      sb.note_request(prob);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_LOCATION:   sb.location = data;
         CSR_SCALE:      sb.scale    = data[30:0];
         CSR_UPPER_TAIL: sb.upper    = data[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we    <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] loc, input logic [30:0] scl, input logic up);
      csr_write(CSR_LOCATION, loc);
      csr_write(CSR_SCALE, {1'b0, scl});
      csr_write(CSR_UPPER_TAIL, {31'd0, up});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_prob();
      case ($urandom_range(0, 5))
         0:       return $urandom >> $urandom_range(0, 31);
         1:       return ~($urandom >> $urandom_range(0, 31));
         2:       return $urandom_range(0, 3);
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   logic [31:0] directed[] = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h5E2D_58D9, 32'h0000_FFFF, 32'hAAAA_AAAA,
      32'h5555_5555, 32'hF000_0000};

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 23;
      recv_idle = 86;
      foreach (directed[i]) send_beat(directed[i]);
      drain();
      csr_write(CSR_SPARE, $urandom);
      configure(32'h0000_0000, 31'd65536, 1'b1);
      foreach (directed[i]) send_beat(directed[i]);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            send_idle = 86;
            recv_idle = 23;
         end else if (ph == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (ph)
            0: configure(32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
            1: configure(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
            2: configure($urandom, 31'd1, 1'b0);
            4: configure($urandom, 31'($urandom_range(1, 31'h7FFF_FFFF)), 1'b1);
            6: configure(32'h0000_0000, 31'd65536, 1'b0);
            default: configure($urandom, 31'($urandom_range(1, 1 << 22)),
                               1'($urandom_range(0, 1)));
         endcase
         if (ph == 6) begin
            @(posedge clock);
            stall_left = 700;
         end
         for (int n = 0; n < ((ph == 6) ? 2 * PHASE_LEN : PHASE_LEN); n++) begin
            send_beat(rand_prob());
         end
         drain();
      end
      if (sb.errors == 0) begin
         $display("tb_gumbel_quantile_core OK");
      end else begin
         $display("tb_gumbel_quantile_core NOT OK");
      end
      $finish;
   end

endmodule
